>>> src/fbik_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbik_pkg
// Shared types and constants for the five-bar inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package fbik_pkg;

  localparam int POS_WIDTH = 17;               // input position width
  localparam int OUT_W     = POS_WIDTH + 1;    // goal position width
  localparam int IW        = ((POS_WIDTH > 18) ? POS_WIDTH : 18) + 4;
  localparam int DIST_W    = OUT_W;            // carriage travel distance
  localparam int SPD_W     = 7;
  localparam int Q_W       = 15;               // scaled speed magnitude
  localparam int PROD_W    = DIST_W + Q_W;
  localparam int REG_W     = 16;
  localparam int NREG      = 8;
  localparam int IDX_W     = 4;
  localparam int SQ_STEPS  = REG_W + 1;        // root bits of 4*(L^2 - z^2)
  localparam int RAD_W     = 2 * SQ_STEPS;
  localparam int SQ_REM_W  = SQ_STEPS + 3;
  localparam logic [SPD_W-1:0] SPD_MAX = SPD_W'(100);

  localparam logic signed [IW-1:0] POS_HI = {{(IW-POS_WIDTH){1'b0}}, {POS_WIDTH{1'b1}}};
  localparam logic signed [IW-1:0] POS_LO = ~POS_HI;

  typedef enum logic [2:0] {
    REG_LINK     = 3'd0,
    REG_END_OFS  = 3'd1,
    REG_CARR_OFS = 3'd2,
    REG_Z_OFS    = 3'd3,
    REG_Z_MIN    = 3'd4,
    REG_Z_MAX    = 3'd5,
    REG_TRAVEL   = 3'd6,
    REG_DEADBAND = 3'd7
  } cfg_reg_t;

  localparam logic [REG_W-1:0] CFG_RESET [NREG] = '{
    16'd44800, 16'd16640, 16'd23040, 16'd2560,
    16'd6400,  16'd42317, 16'd32000, 16'd256
  };

  // scaling choice for the shorter move
  typedef enum logic [1:0] {
    SCL_NONE  = 2'd0,
    SCL_RIGHT = 2'd1,
    SCL_LEFT  = 2'd2
  } scl_t;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] lcur;
    logic signed [POS_WIDTH-1:0] rcur;
    logic signed [POS_WIDTH-1:0] gx;
    logic [SPD_W-1:0]            spd;
    logic                        oob;
  } sq_pay_t;

  typedef struct packed {
    logic                    oob;
    logic signed [OUT_W-1:0] gl;
    logic signed [OUT_W-1:0] gr;
    logic                    l_gt;
    logic                    l_lt;
    logic                    r_gt;
    logic                    r_lt;
    logic [Q_W-1:0]          full;
    scl_t                    scl;
  } dv_pay_t;

endpackage

>>> src/five_bar_inverse_kinematics_sync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_bar_inverse_kinematics_sync
// Pipelined inverse kinematics for a two-carriage five-bar linkage.
// ----------------------------------------------------------------------------
//  channel | ports                              | dir
//  --------+------------------------------------+-----
//  input   | in_valid/in_ready + goal fields    | in
//  result  | out_valid/out_ready + result fields| out
//  config  | cfg_we, cfg_index, cfg_wdata       | in
//
// One transaction per cycle sustained unless the output stalls. Stages: s1,
// s2, radicand, 17 root stages, b1..b5, product, 15 divide stages, output
// register. Depth is set by the bit-per-stage square root and speed divider.
// Synchronous active-low reset clears valids and loads register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module five_bar_inverse_kinematics_sync (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fbik_pkg::POS_WIDTH-1:0] in_left_steps,
  input  logic signed [fbik_pkg::POS_WIDTH-1:0] in_right_steps,
  input  logic signed [fbik_pkg::POS_WIDTH-1:0] in_goal_x,
  input  logic [15:0]                           in_goal_z,
  input  logic [fbik_pkg::SPD_W-1:0]            in_speed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_out_of_bounds,
  output logic signed [fbik_pkg::OUT_W-1:0]     out_goal_left,
  output logic signed [fbik_pkg::OUT_W-1:0]     out_goal_right,
  output logic signed [15:0]                    out_left_speed,
  output logic signed [15:0]                    out_right_speed,
  input  logic                                  cfg_we,
  input  logic [fbik_pkg::IDX_W-1:0]            cfg_index,
  input  logic [fbik_pkg::REG_W-1:0]            cfg_wdata
);
  import fbik_pkg::*;

  function automatic logic signed [15:0] sgn_mag(input logic gt, input logic lt,
                                                 input logic [Q_W-1:0] mag);
    logic signed [15:0] m;
    m = $signed({1'b0, mag});
    if (gt) return m;
    if (lt) return -m;
    return 16'sd0;
  endfunction

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // configuration registers
  logic [REG_W-1:0] cfg_r [NREG];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) cfg_r[i] <= CFG_RESET[i];
    end else if (cfg_we && (cfg_index < IDX_W'(NREG))) begin
      cfg_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  // stage 1: z correction, speed clamp
  logic                     s1_v_r;
  sq_pay_t                  s1_pay_r;
  logic signed [17:0]       s1_zc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_valid;
    if (adv) begin
      s1_pay_r.lcur <= in_left_steps;
      s1_pay_r.rcur <= in_right_steps;
      s1_pay_r.gx   <= in_goal_x;
      s1_pay_r.spd  <= (in_speed > SPD_MAX) ? SPD_MAX : in_speed;
      s1_pay_r.oob  <= 1'b0;
      s1_zc_r       <= $signed({2'b00, in_goal_z}) - $signed({2'b00, cfg_r[REG_Z_OFS]});
    end
  end

  // stage 2: squares, z window
  logic                s2_v_r;
  sq_pay_t             s2_pay_r;
  sq_pay_t             s2_pay_nxt;
  logic [31:0]         s2_lsq_r, s2_zsq_r;
  logic [15:0]         s1_zabs;
  logic signed [17:0]  s1_zc_neg;
  assign s1_zc_neg = -s1_zc_r;
  assign s1_zabs   = s1_zc_r[17] ? s1_zc_neg[15:0] : s1_zc_r[15:0];
  always_comb begin
    s2_pay_nxt     = s1_pay_r;
    s2_pay_nxt.oob = (s1_zc_r < $signed({2'b00, cfg_r[REG_Z_MIN]})) ||
                     (s1_zc_r > $signed({2'b00, cfg_r[REG_Z_MAX]}));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv) begin
      s2_pay_r <= s2_pay_nxt;
      s2_lsq_r <= cfg_r[REG_LINK] * cfg_r[REG_LINK];
      s2_zsq_r <= s1_zabs * s1_zabs;
    end
  end

  // square root pipeline, one root bit per stage; index 0 is the radicand stage
  logic                 sq_v_r    [SQ_STEPS+1];
  sq_pay_t              sq_pay_r  [SQ_STEPS+1];
  logic [RAD_W-1:0]     sq_rad_r  [SQ_STEPS+1];
  logic [SQ_REM_W-1:0]  sq_rem_r  [SQ_STEPS+1];
  logic [SQ_STEPS-1:0]  sq_root_r [SQ_STEPS+1];
  sq_pay_t              sq0_pay_nxt;

  always_comb begin
    sq0_pay_nxt     = s2_pay_r;
    sq0_pay_nxt.oob = s2_pay_r.oob || (s2_zsq_r > s2_lsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (adv) sq_v_r[0] <= s2_v_r;
    if (adv) begin
      sq_pay_r[0]  <= sq0_pay_nxt;
      sq_rad_r[0]  <= {s2_lsq_r - s2_zsq_r, 2'b00};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    logic [SQ_REM_W-1:0] rem2, trial;
    logic                take;
    assign rem2  = {sq_rem_r[k-1][SQ_REM_W-3:0], sq_rad_r[k-1][RAD_W-1 -: 2]};
    assign trial = {1'b0, sq_root_r[k-1], 2'b01};
    assign take  = rem2 >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k] <= 1'b0;
      else if (adv) sq_v_r[k] <= sq_v_r[k-1];
      if (adv) begin
        sq_pay_r[k]  <= sq_pay_r[k-1];
        sq_rad_r[k]  <= {sq_rad_r[k-1][RAD_W-3:0], 2'b00};
        sq_rem_r[k]  <= take ? rem2 - trial : rem2;
        sq_root_r[k] <= {sq_root_r[k-1][SQ_STEPS-2:0], take};
      end
    end
  end

  // b1: base length, x less carriage offset
  logic               b1_v_r;
  sq_pay_t            b1_pay_r;
  logic signed [IW-1:0] b1_base_r, b1_gxc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b1_v_r <= 1'b0;
    else if (adv) b1_v_r <= sq_v_r[SQ_STEPS];
    if (adv) begin
      b1_pay_r  <= sq_pay_r[SQ_STEPS];
      b1_base_r <= $signed(IW'(sq_root_r[SQ_STEPS])) + $signed(IW'(cfg_r[REG_END_OFS]));
      b1_gxc_r  <= IW'(sq_pay_r[SQ_STEPS].gx) - $signed(IW'(cfg_r[REG_CARR_OFS]));
    end
  end

  // b2: right goal, base less both offsets
  logic               b2_v_r;
  sq_pay_t            b2_pay_r;
  logic signed [IW-1:0] b2_gr_r, b2_bm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b2_v_r <= 1'b0;
    else if (adv) b2_v_r <= b1_v_r;
    if (adv) begin
      b2_pay_r <= b1_pay_r;
      b2_gr_r  <= b1_gxc_r + (b1_base_r >>> 1);
      b2_bm_r  <= b1_base_r - $signed(IW'({cfg_r[REG_CARR_OFS], 1'b0}));
    end
  end

  // b3: left goal, right travel check
  logic               b3_v_r;
  sq_pay_t            b3_pay_r;
  sq_pay_t            b3_pay_nxt;
  logic signed [IW-1:0] b3_gr_r, b3_gl_r;
  always_comb begin
    b3_pay_nxt     = b2_pay_r;
    b3_pay_nxt.oob = b2_pay_r.oob || (b2_gr_r > $signed(IW'(cfg_r[REG_TRAVEL])));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) b3_v_r <= 1'b0;
    else if (adv) b3_v_r <= b2_v_r;
    if (adv) begin
      b3_pay_r <= b3_pay_nxt;
      b3_gr_r  <= b2_gr_r;
      b3_gl_r  <= b2_bm_r - b2_gr_r;
    end
  end

  // b4: left travel check, saturation
  logic                    b4_v_r;
  sq_pay_t                 b4_pay_r;
  sq_pay_t                 b4_pay_nxt;
  logic signed [OUT_W-1:0] b4_gr_r, b4_gl_r;
  always_comb begin
    b4_pay_nxt     = b3_pay_r;
    b4_pay_nxt.oob = b3_pay_r.oob || (b3_gl_r > $signed(IW'(cfg_r[REG_TRAVEL])));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) b4_v_r <= 1'b0;
    else if (adv) b4_v_r <= b3_v_r;
    if (adv) begin
      b4_pay_r <= b4_pay_nxt;
      b4_gl_r <= (b3_gl_r > POS_HI) ? OUT_W'(POS_HI) :
                 (b3_gl_r < POS_LO) ? OUT_W'(POS_LO) : OUT_W'(b3_gl_r);
      b4_gr_r <= (b3_gr_r > POS_HI) ? OUT_W'(POS_HI) :
                 (b3_gr_r < POS_LO) ? OUT_W'(POS_LO) : OUT_W'(b3_gr_r);
    end
  end

  // b5: distances and directions
  logic signed [OUT_W:0]   b4_ldiff, b4_rdiff, b4_ldiff_n, b4_rdiff_n;
  assign b4_ldiff   = (OUT_W+1)'(b4_pay_r.lcur) - (OUT_W+1)'(b4_gl_r);
  assign b4_rdiff   = (OUT_W+1)'(b4_pay_r.rcur) - (OUT_W+1)'(b4_gr_r);
  assign b4_ldiff_n = -b4_ldiff;
  assign b4_rdiff_n = -b4_rdiff;

  logic              b5_v_r;
  dv_pay_t           b5_pay_r;
  logic [DIST_W-1:0] b5_ld_r, b5_rd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b5_v_r <= 1'b0;
    else if (adv) b5_v_r <= b4_v_r;
    if (adv) begin
      b5_pay_r.oob  <= b4_pay_r.oob;
      b5_pay_r.gl   <= b4_gl_r;
      b5_pay_r.gr   <= b4_gr_r;
      b5_pay_r.l_gt <= b4_ldiff > 0;
      b5_pay_r.l_lt <= b4_ldiff[OUT_W];
      b5_pay_r.r_gt <= b4_rdiff > 0;
      b5_pay_r.r_lt <= b4_rdiff[OUT_W];
      b5_pay_r.full <= {b4_pay_r.spd, 8'd0};
      b5_pay_r.scl  <= SCL_NONE;
      b5_ld_r <= b4_ldiff[OUT_W] ? b4_ldiff_n[DIST_W-1:0] : b4_ldiff[DIST_W-1:0];
      b5_rd_r <= b4_rdiff[OUT_W] ? b4_rdiff_n[DIST_W-1:0] : b4_rdiff[DIST_W-1:0];
    end
  end

  // divider pipeline; index 0 holds the product small * full
  logic              dv_v_r   [Q_W+1];
  dv_pay_t           dv_pay_r [Q_W+1];
  logic [PROD_W-1:0] dv_rem_r [Q_W+1];
  logic [DIST_W-1:0] dv_den_r [Q_W+1];
  logic [Q_W-1:0]    dv_q_r   [Q_W+1];

  logic [DIST_W-1:0] b5_small, b5_large;
  scl_t              b5_scl;
  dv_pay_t           dv0_pay_nxt;
  always_comb begin
    if (b5_ld_r > b5_rd_r) begin
      b5_scl = SCL_RIGHT; b5_small = b5_rd_r; b5_large = b5_ld_r;
    end else if (b5_rd_r > b5_ld_r) begin
      b5_scl = SCL_LEFT;  b5_small = b5_ld_r; b5_large = b5_rd_r;
    end else begin
      b5_scl = SCL_NONE;  b5_small = '0;      b5_large = DIST_W'(1);
    end
  end

  always_comb begin
    dv0_pay_nxt     = b5_pay_r;
    dv0_pay_nxt.scl = b5_scl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= b5_v_r;
    if (adv) begin
      dv_pay_r[0] <= dv0_pay_nxt;
      dv_rem_r[0] <= b5_small * b5_pay_r.full;
      dv_den_r[0] <= b5_large;
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_div
    logic [PROD_W-1:0] trial;
    logic              take;
    assign trial = PROD_W'(dv_den_r[j-1]) << (Q_W - j);
    assign take  = dv_rem_r[j-1] >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (adv) dv_v_r[j] <= dv_v_r[j-1];
      if (adv) begin
        dv_pay_r[j] <= dv_pay_r[j-1];
        dv_den_r[j] <= dv_den_r[j-1];
        dv_rem_r[j] <= take ? dv_rem_r[j-1] - trial : dv_rem_r[j-1];
        dv_q_r[j]   <= {dv_q_r[j-1][Q_W-2:0], take};
      end
    end
  end

  // output register
  dv_pay_t           fin;
  logic [Q_W-1:0]    fin_sc;
  logic              fin_ok;
  logic [Q_W-1:0]    l_mag, r_mag;
  assign fin    = dv_pay_r[Q_W];
  assign fin_sc = dv_q_r[Q_W];
  assign fin_ok = {1'b0, fin_sc} >= cfg_r[REG_DEADBAND];
  always_comb begin
    l_mag = fin.full;
    r_mag = fin.full;
    unique case (fin.scl)
      SCL_RIGHT: if (fin_ok) r_mag = fin_sc;
      SCL_LEFT:  if (fin_ok) l_mag = fin_sc;
      default:   ;
    endcase
  end

  logic                    out_oob_r;
  logic signed [OUT_W-1:0] out_gl_r, out_gr_r;
  logic signed [15:0]      out_ls_r, out_rs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_v_r[Q_W];
    if (adv) begin
      out_oob_r <= fin.oob;
      out_gl_r  <= fin.oob ? '0 : fin.gl;
      out_gr_r  <= fin.oob ? '0 : fin.gr;
      out_ls_r  <= fin.oob ? '0 : sgn_mag(fin.l_gt, fin.l_lt, l_mag);
      out_rs_r  <= fin.oob ? '0 : sgn_mag(fin.r_gt, fin.r_lt, r_mag);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_out_of_bounds = out_oob_r;
  assign out_goal_left     = out_gl_r;
  assign out_goal_right    = out_gr_r;
  assign out_left_speed    = out_ls_r;
  assign out_right_speed   = out_rs_r;

endmodule
